### rtl/hsl_pkg.sv
// Shared types and constants of the hue shift and saturation set block.
// Used by every module of the block; depends on nothing.
package hsl_pkg;

    localparam int unsigned HueFull = 1536;
    localparam logic [8:0] SatFull = 9'd256;

    localparam logic [1:0] CfgHueShift = 2'd0;
    localparam logic [1:0] CfgSatLevel = 2'd1;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_pix_out;

    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } t_sel;

    // Classified pixel handed from the front to the back.
    typedef struct packed {
        t_sel       sel;
        logic       neg;
        logic [7:0] mag;
        logic [7:0] delta;
        logic [8:0] s;
    } t_cls;

    typedef struct packed {
        logic [11:0] hue_shift;
        logic [8:0]  sat_level;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_qstat;

    // Saturate one channel term (exact value times 65536) to 0..255.
    function automatic logic [7:0] chan(input logic signed [26:0] v);
        logic [7:0] res;
        if (v < 0) begin
            res = 8'd0;
        end else if (v[26:16] > 11'd255) begin
            res = 8'd255;
        end else begin
            res = v[23:16];
        end
        return res;
    endfunction

endpackage

### rtl/hsl_front.sv
// Front of the hue shift block: takes pixels and classifies them.
// Depends on hsl_pkg.
module hsl_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  hsl_pkg::t_pix_in i_pix,
    input  logic             i_q_full,
    output logic             o_push,
    output hsl_pkg::t_cls    o_cls
);
    import hsl_pkg::*;

    logic       r_fv;
    t_cls       r_cls;
    t_cls       n_cls;
    logic [7:0] mx;
    logic [7:0] mn;
    logic signed [8:0] diff;
    logic       load;

    always_comb begin
        mx = i_pix.in_red;
        mn = i_pix.in_red;
        if (i_pix.in_green > mx) mx = i_pix.in_green;
        if (i_pix.in_blue > mx) mx = i_pix.in_blue;
        if (i_pix.in_green < mn) mn = i_pix.in_green;
        if (i_pix.in_blue < mn) mn = i_pix.in_blue;
        // Ties go to red, then green, then blue.
        if (i_pix.in_red >= i_pix.in_green && i_pix.in_red >= i_pix.in_blue) begin
            n_cls.sel = SEL_RED;
            diff = $signed({1'b0, i_pix.in_green}) - $signed({1'b0, i_pix.in_blue});
        end else if (i_pix.in_green >= i_pix.in_blue) begin
            n_cls.sel = SEL_GREEN;
            diff = $signed({1'b0, i_pix.in_blue}) - $signed({1'b0, i_pix.in_red});
        end else begin
            n_cls.sel = SEL_BLUE;
            diff = $signed({1'b0, i_pix.in_red}) - $signed({1'b0, i_pix.in_green});
        end
        n_cls.neg = diff[8];
        n_cls.mag = diff[8] ? 8'(-diff) : diff[7:0];
        n_cls.delta = mx - mn;
        n_cls.s = {1'b0, mx} + {1'b0, mn};
    end

    assign o_push = r_fv && !i_q_full;
    assign load = !r_fv || o_push;
    assign o_stall = !load;
    assign o_cls = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (load) begin
            r_fv <= i_valid;
        end
        if (load && i_valid) begin
            r_cls <= n_cls;
        end
    end

endmodule

### rtl/hsl_queue.sv
// Short queue between the front and the back of the hue shift block.
// Depends on hsl_pkg.
module hsl_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hsl_pkg::t_cls    i_data,
    input  logic             i_pop,
    output hsl_pkg::t_cls    o_data,
    output hsl_pkg::t_qstat  o_stat
);
    import hsl_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

    t_cls            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;

    assign o_data = r_mem[r_rd];
    assign o_stat.full = (r_cnt == CntW'(DEPTH));
    assign o_stat.not_empty = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrLast) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrLast) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### rtl/hsl_back.sv
// Back of the hue shift block: divider, hue rotation and RGB rebuild
// pipeline with its output register. Depends on hsl_pkg.
module hsl_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hsl_pkg::t_cfg     i_cfg,
    input  hsl_pkg::t_cls     i_cls,
    input  logic              i_avail,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output hsl_pkg::t_pix_out o_pix
);
    import hsl_pkg::*;

    typedef struct packed {
        t_sel               sel;
        logic               neg;
        logic               grey;
        logic [7:0]         delta;
        logic [8:0]         rem;
        logic [8:0]         q;
        logic [8:0]         s;
        logic [10:0]        h;
        logic [15:0]        cn;
        logic [8:0]         f;
        logic signed [26:0] cm;
        logic signed [26:0] xm;
        logic signed [26:0] mm;
    } t_work;

    // One restoring step of the quotient.
    function automatic t_work div_step(input t_work w);
        t_work      o;
        logic [8:0] r2;
        o = w;
        r2 = {w.rem[7:0], 1'b0};
        if (r2 >= {1'b0, w.delta}) begin
            o.rem = r2 - {1'b0, w.delta};
            o.q = {w.q[7:0], 1'b1};
        end else begin
            o.rem = r2;
            o.q = {w.q[7:0], 1'b0};
        end
        return o;
    endfunction

    t_work    r_stg [6];
    t_work    n_stg [6];
    logic     r_v [6];
    logic     ld [7];
    logic     r_ov;
    t_pix_out r_pix;
    t_pix_out n_pix;

    logic signed [13:0] hraw;
    logic [12:0]        hv;
    logic [12:0]        hm;
    logic [8:0]         sat;
    logic [8:0]         lum_dist;
    logic [7:0]         light;
    logic [24:0]        xprod;
    logic [2:0]         sector;

    always_comb begin
        // Stage 0: integer bit of the quotient, then two fraction bits.
        n_stg[0] = '0;
        n_stg[0].sel = i_cls.sel;
        n_stg[0].neg = i_cls.neg;
        n_stg[0].grey = (i_cls.delta == 8'd0);
        n_stg[0].delta = i_cls.delta;
        n_stg[0].s = i_cls.s;
        if (i_cls.mag == i_cls.delta) begin
            n_stg[0].q = 9'd1;
            n_stg[0].rem = 9'd0;
        end else begin
            n_stg[0].q = 9'd0;
            n_stg[0].rem = {1'b0, i_cls.mag};
        end
        n_stg[0] = div_step(div_step(n_stg[0]));

        n_stg[1] = div_step(div_step(div_step(r_stg[0])));
        n_stg[2] = div_step(div_step(div_step(r_stg[1])));

        // Stage 3: hue, rotated and wrapped into 0..1535.
        n_stg[3] = r_stg[2];
        case (r_stg[2].sel)
            SEL_RED:   hraw = 14'sd0;
            SEL_GREEN: hraw = 14'sd512;
            default:   hraw = 14'sd1024;
        endcase
        if (r_stg[2].neg) begin
            hraw = hraw - $signed({5'b0, r_stg[2].q});
        end else begin
            hraw = hraw + $signed({5'b0, r_stg[2].q});
        end
        if (r_stg[2].grey) begin
            hraw = 14'sd0;
        end
        hv = 13'(hraw + {{2{i_cfg.hue_shift[11]}}, i_cfg.hue_shift} + 14'sd3072);
        if (hv >= 13'd6144) begin
            hm = hv - 13'd6144;
        end else if (hv >= 13'd4608) begin
            hm = hv - 13'd4608;
        end else if (hv >= 13'd3072) begin
            hm = hv - 13'd3072;
        end else if (hv >= 13'(HueFull)) begin
            hm = hv - 13'(HueFull);
        end else begin
            hm = hv;
        end
        n_stg[3].h = hm[10:0];

        // Stage 4: chroma numerator and hue fraction.
        n_stg[4] = r_stg[3];
        sat = (i_cfg.sat_level > SatFull) ? SatFull : i_cfg.sat_level;
        lum_dist = (r_stg[3].s >= 9'd255) ? r_stg[3].s - 9'd255 : 9'd255 - r_stg[3].s;
        light = 8'(9'd255 - lum_dist);
        n_stg[4].cn = 16'({8'b0, light} * {7'b0, sat});
        if (r_stg[3].h[8]) begin
            n_stg[4].f = 9'(10'd512 - {1'b0, r_stg[3].h[8:0]});
        end else begin
            n_stg[4].f = r_stg[3].h[8:0];
        end

        // Stage 5: the three channel terms over 65536.
        n_stg[5] = r_stg[4];
        xprod = r_stg[4].cn * r_stg[4].f;
        n_stg[5].mm = $signed({3'b0, r_stg[4].s, 15'b0})
                    - $signed({4'b0, r_stg[4].cn, 7'b0});
        n_stg[5].cm = n_stg[5].mm + $signed({3'b0, r_stg[4].cn, 8'b0});
        n_stg[5].xm = n_stg[5].mm + $signed({2'b0, xprod});

        // Output: pick terms by sextant.
        sector = r_stg[5].h[10:8];
        case (sector)
            3'd0: begin
                n_pix.out_red = chan(r_stg[5].cm);
                n_pix.out_green = chan(r_stg[5].xm);
                n_pix.out_blue = chan(r_stg[5].mm);
            end
            3'd1: begin
                n_pix.out_red = chan(r_stg[5].xm);
                n_pix.out_green = chan(r_stg[5].cm);
                n_pix.out_blue = chan(r_stg[5].mm);
            end
            3'd2: begin
                n_pix.out_red = chan(r_stg[5].mm);
                n_pix.out_green = chan(r_stg[5].cm);
                n_pix.out_blue = chan(r_stg[5].xm);
            end
            3'd3: begin
                n_pix.out_red = chan(r_stg[5].mm);
                n_pix.out_green = chan(r_stg[5].xm);
                n_pix.out_blue = chan(r_stg[5].cm);
            end
            3'd4: begin
                n_pix.out_red = chan(r_stg[5].xm);
                n_pix.out_green = chan(r_stg[5].mm);
                n_pix.out_blue = chan(r_stg[5].cm);
            end
            default: begin
                n_pix.out_red = chan(r_stg[5].cm);
                n_pix.out_green = chan(r_stg[5].mm);
                n_pix.out_blue = chan(r_stg[5].xm);
            end
        endcase
    end

    always_comb begin
        ld[6] = !r_ov || !i_stall;
        for (int k = 5; k >= 0; k--) begin
            ld[k] = !r_v[k] || ld[k+1];
        end
    end

    assign o_pop = i_avail && ld[0];
    assign o_valid = r_ov;
    assign o_pix = r_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_v[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else begin
            if (ld[0]) begin
                r_v[0] <= i_avail;
            end
            for (int k = 1; k < 6; k++) begin
                if (ld[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (ld[6]) begin
                r_ov <= r_v[5];
            end
        end
        for (int k = 0; k < 6; k++) begin
            if (ld[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
        if (ld[6]) begin
            r_pix <= n_pix;
        end
    end

endmodule

### rtl/hsl_hue_shift_saturation_set.sv
// Hue rotation and saturation setting of a stream of 8-bit RGB pixels.
// The block takes one pixel per clock and gives one adjusted pixel per pixel,
// in order. A pixel transfer is accepted in the first stage, which finds the
// maximum, minimum and dominant channel; it then waits in a short queue and
// runs through a seven-stage back end: three stages of a pipelined restoring
// divider for the hue in 1/256 sextant units, a stage that adds the hue shift
// and wraps into 0 to 1535, a stage that forms the chroma from lightness and
// saturation, a stage that forms the three channel terms, and the output
// register. The sustained rate is one pixel per clock, limited by nothing but
// downstream stall. Configuration (index 0: signed hue shift in 1/256 sextant,
// index 1: saturation level with 256 as full, larger values acting as full) is
// written through the plain write port while the block is idle; writes to
// other indexes are ignored.
// Depends on hsl_pkg, hsl_front, hsl_queue and hsl_back.
module hsl_hue_shift_saturation_set #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  hsl_pkg::t_pix_in  i_pix,
    output logic              o_valid,
    input  logic              i_stall,
    output hsl_pkg::t_pix_out o_pix,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [11:0]       i_cfg_data
);
    import hsl_pkg::*;

    logic [11:0] r_hue_shift;
    logic [8:0]  r_sat_level;
    t_cfg        cfg;
    t_cls        push_cls;
    t_cls        head_cls;
    t_qstat      qstat;
    logic        push;
    logic        pop;

    // Configuration registers; the user must change them only while no pixel is in flight (not enforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_shift <= 12'd0;
            r_sat_level <= SatFull;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgHueShift: r_hue_shift <= i_cfg_data;
                CfgSatLevel: r_sat_level <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign cfg.hue_shift = r_hue_shift;
    assign cfg.sat_level = r_sat_level;

    hsl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_pix    (i_pix),
        .i_q_full (qstat.full),
        .o_push   (push),
        .o_cls    (push_cls)
    );

    hsl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cls),
        .i_pop   (pop),
        .o_data  (head_cls),
        .o_stat  (qstat)
    );

    hsl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cls   (head_cls),
        .i_avail (qstat.not_empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_pix   (o_pix)
    );

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && qstat.full))
        else $error("queue push while full");

    // The back only pops an entry that is present.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> qstat.not_empty)
        else $error("queue pop while empty");

    // Reset leaves the saturation at full.
    a_sat_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_sat_level == SatFull)
        else $error("saturation level not full after reset");

endmodule

### dv/tb_hsl_hue_shift_saturation_set.sv
// Self-checking testbench of the hue shift and saturation set block.
// Drives random and directed pixels over several register settings and checks
// every result against a behavioral prediction; depends on hsl_pkg and the RTL.

// Scoreboard: computes the adjusted pixel for each accepted input and holds
// the predictions in order until the block delivers them.
class hsl_pixel_board;
    hsl_pkg::t_pix_out pending_pix[$];
    logic [11:0] hue_shift;
    logic [8:0]  sat_level;
    int          mismatches;

    function new();
        hue_shift = 12'd0;
        sat_level = 9'd256;
        mismatches = 0;
    endfunction

    function logic [7:0] clamp_channel(longint v);
        longint q;
        if (v <= 0) begin
            return 8'd0;
        end
        q = v / 65536;
        if (q > 255) begin
            return 8'd255;
        end
        return q[7:0];
    endfunction

    // Hue fraction num*256/den with truncation toward zero.
    function int sextant_frac(int num, int den);
        int q;
        q = ((num < 0 ? -num : num) * 256) / den;
        return num < 0 ? -q : q;
    endfunction

    function void note_input(hsl_pkg::t_pix_in px);
        int r, g, b, mx, mn, dl, h, sat, s, lum_dist, f;
        longint cn, c_t, x_t, m_t, ro, go, bo;
        hsl_pkg::t_pix_out res;
        r = px.in_red;
        g = px.in_green;
        b = px.in_blue;
        mx = r; mn = r; h = 0;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        dl = mx - mn;
        // A grey pixel keeps hue zero.
        if (dl != 0) begin
            if (mx == r) h = sextant_frac(g - b, dl);
            else if (mx == g) h = 512 + sextant_frac(b - r, dl);
            else h = 1024 + sextant_frac(r - g, dl);
        end
        h = h + $signed(hue_shift);
        h = h % 1536;
        if (h < 0) h += 1536;
        sat = (sat_level > 9'd256) ? 256 : int'(sat_level);
        s = mx + mn;
        lum_dist = (s > 255) ? s - 255 : 255 - s;
        cn = longint'(255 - lum_dist) * sat;
        f = (h % 512) - 256;
        if (f < 0) f = -f;
        f = 256 - f;
        c_t = cn * 256;
        x_t = cn * f;
        m_t = longint'(s) * 32768 - cn * 128;
        case (h / 256)
            0: begin ro = c_t + m_t; go = x_t + m_t; bo = m_t; end
            1: begin ro = x_t + m_t; go = c_t + m_t; bo = m_t; end
            2: begin ro = m_t; go = c_t + m_t; bo = x_t + m_t; end
            3: begin ro = m_t; go = x_t + m_t; bo = c_t + m_t; end
            4: begin ro = x_t + m_t; go = m_t; bo = c_t + m_t; end
            default: begin ro = c_t + m_t; go = m_t; bo = x_t + m_t; end
        endcase
        res.out_red = clamp_channel(ro);
        res.out_green = clamp_channel(go);
        res.out_blue = clamp_channel(bo);
        pending_pix.push_back(res);
    endfunction

    function void check_result(hsl_pkg::t_pix_out got);
        hsl_pkg::t_pix_out want;
        if (pending_pix.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending_pix.pop_front();
        if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
                got.out_blue !== want.out_blue) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                         want.out_red, want.out_green, want.out_blue,
                         got.out_red, got.out_green, got.out_blue);
            end
        end
    endfunction
endclass

module tb_hsl_hue_shift_saturation_set;
    import hsl_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int DrainCycles = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_pix_in     i_pix = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_pix_out    o_pix;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [11:0] i_cfg_data = '0;

    hsl_pixel_board board = new();
    int cycle_count = 0;
    // Idle percentages for the sender and the receiver, changed per phase.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    hsl_hue_shift_saturation_set i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_pix(i_pix), .o_valid(o_valid), .i_stall(i_stall), .o_pix(o_pix),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // The receiver stalls at random; results are sampled at the same edge at
    // which they are accepted, before the new stall value takes effect.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_result(o_pix);
        end
        i_stall <= ($urandom_range(99) < recv_idle_pct);
        if (cycle_count > CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Drive one pixel transfer, inserting sender idle cycles first. Valid
    // stays high after the transfer so that back-to-back pixels leave no gap;
    // it drops when the sender idles. The prediction is noted at the edge
    // where the transfer is accepted.
    task automatic send_pixel(input t_pix_in px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pix <= px;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        board.note_input(px);
    endtask

    // Registers are written only when every expected result has arrived and
    // the pipeline has had time to empty.
    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        i_valid <= 1'b0;
        while (board.pending_pix.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CfgHueShift) board.hue_shift = val;
        else if (idx == CfgSatLevel) board.sat_level = val[8:0];
    endtask

    task automatic send_random(input int count);
        t_pix_in px;
        for (int k = 0; k < count; k++) begin
            px = t_pix_in'($urandom);
            // Some pixels are grey or have channel ties to hit the edge cases.
            case ($urandom_range(7))
                0: px.in_green = px.in_red;
                1: begin px.in_green = px.in_red; px.in_blue = px.in_red; end
                2: px.in_blue = px.in_green;
                default: ;
            endcase
            send_pixel(px);
        end
    endtask

    initial begin
        logic [11:0] shifts[8];
        logic [8:0]  sats[8];
        shifts = '{12'd0, 12'd1536, -12'sd1536, 12'h7FF, 12'h800, 12'd100, -12'sd700, 12'd768};
        sats = '{9'd256, 9'd0, 9'd511, 9'd128, 9'd300, 9'd1, 9'd255, 9'd200};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pixels at reset settings: extremes, greys, every sextant.
        send_pixel('{8'd0, 8'd0, 8'd0});
        send_pixel('{8'd255, 8'd255, 8'd255});
        send_pixel('{8'd128, 8'd128, 8'd128});
        send_pixel('{8'd255, 8'd0, 8'd0});
        send_pixel('{8'd255, 8'd255, 8'd0});
        send_pixel('{8'd0, 8'd255, 8'd0});
        send_pixel('{8'd0, 8'd255, 8'd255});
        send_pixel('{8'd0, 8'd0, 8'd255});
        send_pixel('{8'd255, 8'd0, 8'd255});
        send_pixel('{8'd255, 8'd254, 8'd1});
        send_pixel('{8'd1, 8'd0, 8'd255});
        send_pixel('{8'd170, 8'd85, 8'd85});
        send_pixel('{8'hAA, 8'h55, 8'hAA});
        send_pixel('{8'h55, 8'hAA, 8'h55});
        // An unknown register index must be ignored.
        write_reg(2'd3, 12'hFFF);
        write_reg(2'd2, 12'h123);
        send_pixel('{8'd200, 8'd30, 8'd90});

        // Three phases with different idling, each sweeping through several settings.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 46 : 0;
            recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 36 : 0;
            for (int k = 0; k < 8; k++) begin
                write_reg(CfgHueShift, (k == 7) ? 12'($urandom) : shifts[(k + phase) % 8]);
                write_reg(CfgSatLevel, {3'b0, sats[(k + 3 * phase) % 8]});
                send_random(35);
            end
        end
        recv_idle_pct = 0;
        i_valid <= 1'b0;

        while (board.pending_pix.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
